[rtl/core/rdzr_pkg.sv]
// ----------------------------------------------------------------------------
// rdzr_pkg
// Shared widths and defaults for the radial dead zone rescaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rdzr_pkg;

  localparam int unsigned STICK_W        = 16;    // raw and scaled component width
  localparam int unsigned RAD_W          = 15;    // dead zone radius width
  localparam int unsigned FULL_SCALE_DEF = 32767;

endpackage

`default_nettype wire

[rtl/core/rdzr_if.sv]
// ----------------------------------------------------------------------------
// rdzr_if
// Valid/ready channels of the rescaler: stick samples, results, radius writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdzr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rdzr_pkg::STICK_W-1:0] stick_x;
  logic signed [rdzr_pkg::STICK_W-1:0] stick_y;
  modport source (output valid, stick_x, stick_y, input ready);
  modport sink   (input valid, stick_x, stick_y, output ready);
endinterface

interface rdzr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rdzr_pkg::STICK_W-1:0] scaled_x;
  logic signed [rdzr_pkg::STICK_W-1:0] scaled_y;
  logic                                inside_zone;
  modport source (output valid, scaled_x, scaled_y, inside_zone, input ready);
  modport sink   (input valid, scaled_x, scaled_y, inside_zone, output ready);
endinterface

interface rdzr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rdzr_pkg::RAD_W-1:0]  zone_radius;
  modport source (output valid, zone_radius, input ready);
  modport sink   (input valid, zone_radius, output ready);
endinterface

`default_nettype wire

[rtl/core/radial_dead_zone_rescale_top.sv]
// ----------------------------------------------------------------------------
// radial_dead_zone_rescale_top
// Radial dead zone with rescaling: bit-serial pipelined root and dividers.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_bus    sink       stick_x, stick_y
// out_bus   source     scaled_x, scaled_y, inside_zone
// cfg_bus   sink       zone_radius (always ready)
//
// One beat per cycle while out_bus is not stalled; 3 front stages, 24 root
// stages, 23 rescale divide stages, 16 component divide stages, 3 glue.
// The root and the dividers resolve one result bit per stage.
// Reset clears the radius and all stage valids.
// A stall at the output freezes the whole pipeline; in_bus.ready is low then.
`default_nettype none

module radial_dead_zone_rescale_top #(
  parameter int unsigned FULL_SCALE = rdzr_pkg::FULL_SCALE_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  rdzr_in_if.sink      in_bus,
  rdzr_out_if.source   out_bus,
  rdzr_cfg_if.sink     cfg_bus
);

  localparam int unsigned RT_N = 24;   // root bits of the Q.8 magnitude
  localparam int unsigned D1_N = 23;   // rescaled magnitude bits
  localparam int unsigned D2_N = 16;   // component quotient bits

  localparam logic [14:0] FS15    = 15'(FULL_SCALE);
  localparam logic [14:0] RAD_MAX = 15'(FULL_SCALE - 1);
  localparam logic [22:0] FULL_Q  = 23'(FULL_SCALE * 256);

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [14:0] rad;
    logic        in_zone;
  } side_t;

  logic adv;
  logic out_v_r;
  assign adv          = !out_v_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign cfg_bus.ready = 1'b1;

  // radius register
  logic [14:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_bus.valid) begin
      radius_r <= cfg_bus.zone_radius;
    end
  end

  // ---- stage A: capture
  logic               a_v_r;
  logic signed [15:0] a_x_r, a_y_r;
  logic [14:0]        a_rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_bus.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r   <= in_bus.stick_x;
      a_y_r   <= in_bus.stick_y;
      a_rad_r <= (radius_r > RAD_MAX) ? RAD_MAX : radius_r;
    end
  end

  // ---- stage B: squares
  logic [15:0] a_ax, a_ay;
  assign a_ax = a_x_r[15] ? 16'(~a_x_r + 16'sd1) : 16'(a_x_r);
  assign a_ay = a_y_r[15] ? 16'(~a_y_r + 16'sd1) : 16'(a_y_r);

  logic        b_v_r;
  logic [31:0] b_ax2_r, b_ay2_r;
  logic [29:0] b_rr_r;
  side_t       b_sb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_ax2_r <= 32'(a_ax) * 32'(a_ax);
      b_ay2_r <= 32'(a_ay) * 32'(a_ay);
      b_rr_r  <= 30'(a_rad_r) * 30'(a_rad_r);
      b_sb_r  <= '{neg_x: a_x_r[15], neg_y: a_y_r[15], ax: a_ax, ay: a_ay,
                   rad: a_rad_r, in_zone: 1'b0};
    end
  end

  // ---- stage C: sum of squares and exact zone test
  logic [31:0] b_sq;
  assign b_sq = b_ax2_r + b_ay2_r;

  side_t b_sb_z;
  always_comb begin
    b_sb_z         = b_sb_r;
    b_sb_z.in_zone = (b_sq <= {2'b00, b_rr_r});
  end

  logic [RT_N:0]      rt_v_r;
  logic [26:0]        rt_rem_r [0:RT_N];
  logic [RT_N-1:0]    rt_q_r   [0:RT_N];
  logic [31:0]        rt_sq_r  [0:RT_N];
  side_t              rt_sb_r  [0:RT_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (adv) begin
      rt_v_r[0] <= b_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rt_rem_r[0] <= '0;
      rt_q_r[0]   <= '0;
      rt_sq_r[0]  <= b_sq;
      rt_sb_r[0]  <= b_sb_z;
    end
  end

  // ---- root of sq << 16, two radicand bits per stage
  for (genvar k = 0; k < RT_N; k++) begin : g_root
    logic [26:0] trial, subt;
    logic        ge;
    assign trial = {rt_rem_r[k][24:0], rt_sq_r[k][31:30]};
    assign subt  = {1'b0, rt_q_r[k], 2'b01};
    assign ge    = (trial >= subt);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        rt_v_r[k+1] <= rt_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rt_rem_r[k+1] <= ge ? (trial - subt) : trial;
        rt_q_r[k+1]   <= {rt_q_r[k][RT_N-2:0], ge};
        rt_sq_r[k+1]  <= {rt_sq_r[k][29:0], 2'b00};
        rt_sb_r[k+1]  <= rt_sb_r[k];
      end
    end
  end

  // ---- stage D: clamp, offset and scale numerator
  logic [RT_N-1:0] rt_m;
  logic [22:0]     d_clamp, d_diff;
  assign rt_m    = rt_q_r[RT_N];
  assign d_clamp = (rt_m > {1'b0, FULL_Q}) ? FULL_Q : rt_m[22:0];
  assign d_diff  = d_clamp - {rt_sb_r[RT_N].rad, 8'd0};

  logic [D1_N:0]   d1_v_r;
  logic [14:0]     d1_rem_r [0:D1_N];
  logic [22:0]     d1_low_r [0:D1_N];
  logic [22:0]     d1_q_r   [0:D1_N];
  logic [14:0]     d1_den_r [0:D1_N];
  logic [RT_N-1:0] d1_m_r   [0:D1_N];
  side_t           d1_sb_r  [0:D1_N];
  logic [37:0]     d_num;
  assign d_num = 38'(d_diff) * 38'(FS15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r[0] <= 1'b0;
    end else if (adv) begin
      d1_v_r[0] <= rt_v_r[RT_N];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_rem_r[0] <= d_num[37:23];
      d1_low_r[0] <= d_num[22:0];
      d1_q_r[0]   <= '0;
      d1_den_r[0] <= FS15 - rt_sb_r[RT_N].rad;
      d1_m_r[0]   <= rt_m;
      d1_sb_r[0]  <= rt_sb_r[RT_N];
    end
  end

  // ---- restoring divide by (FULL_SCALE - r), one quotient bit per stage
  for (genvar j = 0; j < D1_N; j++) begin : g_div1
    logic [15:0] trial;
    logic        ge;
    assign trial = {d1_rem_r[j], d1_low_r[j][22]};
    assign ge    = (trial >= {1'b0, d1_den_r[j]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        d1_v_r[j+1] <= d1_v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_rem_r[j+1] <= 15'(ge ? (trial - {1'b0, d1_den_r[j]}) : trial);
        d1_low_r[j+1] <= {d1_low_r[j][21:0], 1'b0};
        d1_q_r[j+1]   <= {d1_q_r[j][21:0], ge};
        d1_den_r[j+1] <= d1_den_r[j];
        d1_m_r[j+1]   <= d1_m_r[j];
        d1_sb_r[j+1]  <= d1_sb_r[j];
      end
    end
  end

  // ---- stage E: component products
  logic [22:0]     e_s;
  assign e_s = d1_q_r[D1_N];

  logic [D2_N:0]   d2_v_r;
  logic [23:0]     d2_rx_r  [0:D2_N];
  logic [23:0]     d2_ry_r  [0:D2_N];
  logic [15:0]     d2_lx_r  [0:D2_N];
  logic [15:0]     d2_ly_r  [0:D2_N];
  logic [15:0]     d2_qx_r  [0:D2_N];
  logic [15:0]     d2_qy_r  [0:D2_N];
  logic [RT_N-1:0] d2_m_r   [0:D2_N];
  side_t           d2_sb_r  [0:D2_N];
  logic [38:0]     e_px, e_py;
  assign e_px = 39'(e_s) * 39'(d1_sb_r[D1_N].ax);
  assign e_py = 39'(e_s) * 39'(d1_sb_r[D1_N].ay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r[0] <= 1'b0;
    end else if (adv) begin
      d2_v_r[0] <= d1_v_r[D1_N];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d2_rx_r[0] <= {1'b0, e_px[38:16]};
      d2_ry_r[0] <= {1'b0, e_py[38:16]};
      d2_lx_r[0] <= e_px[15:0];
      d2_ly_r[0] <= e_py[15:0];
      d2_qx_r[0] <= '0;
      d2_qy_r[0] <= '0;
      d2_m_r[0]  <= d1_m_r[D1_N];
      d2_sb_r[0] <= d1_sb_r[D1_N];
    end
  end

  // ---- two lanes of restoring divide by the unclamped magnitude
  for (genvar i = 0; i < D2_N; i++) begin : g_div2
    logic [24:0] tx, ty, mm;
    logic        gx, gy;
    assign mm = {1'b0, d2_m_r[i]};
    assign tx = {d2_rx_r[i], d2_lx_r[i][15]};
    assign ty = {d2_ry_r[i], d2_ly_r[i][15]};
    assign gx = (tx >= mm);
    assign gy = (ty >= mm);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[i+1] <= 1'b0;
      end else if (adv) begin
        d2_v_r[i+1] <= d2_v_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d2_rx_r[i+1] <= 24'(gx ? (tx - mm) : tx);
        d2_ry_r[i+1] <= 24'(gy ? (ty - mm) : ty);
        d2_lx_r[i+1] <= {d2_lx_r[i][14:0], 1'b0};
        d2_ly_r[i+1] <= {d2_ly_r[i][14:0], 1'b0};
        d2_qx_r[i+1] <= {d2_qx_r[i][14:0], gx};
        d2_qy_r[i+1] <= {d2_qy_r[i][14:0], gy};
        d2_m_r[i+1]  <= d2_m_r[i];
        d2_sb_r[i+1] <= d2_sb_r[i];
      end
    end
  end

  // ---- stage F: saturate, restore sign, output register
  side_t       f_sb;
  logic [15:0] f_sx, f_sy, f_ox, f_oy;
  assign f_sb = d2_sb_r[D2_N];
  assign f_sx = (d2_qx_r[D2_N] > {1'b0, FS15}) ? {1'b0, FS15} : d2_qx_r[D2_N];
  assign f_sy = (d2_qy_r[D2_N] > {1'b0, FS15}) ? {1'b0, FS15} : d2_qy_r[D2_N];
  assign f_ox = f_sb.in_zone ? '0 : (f_sb.neg_x ? 16'(~f_sx + 16'd1) : f_sx);
  assign f_oy = f_sb.in_zone ? '0 : (f_sb.neg_y ? 16'(~f_sy + 16'd1) : f_sy);

  logic [15:0] out_x_r, out_y_r;
  logic        out_in_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= d2_v_r[D2_N];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r  <= f_ox;
      out_y_r  <= f_oy;
      out_in_r <= f_sb.in_zone;
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.scaled_x    = signed'(out_x_r);
  assign out_bus.scaled_y    = signed'(out_y_r);
  assign out_bus.inside_zone = out_in_r;

  // ---- checks
  a_zone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_in_r |-> (out_x_r == '0) && (out_y_r == '0))
    else $error("dead zone beat with non-zero components");

  a_no_min_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_x_r != 16'h8000) && (out_y_r != 16'h8000))
    else $error("component beyond full scale");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rt_v_r[RT_N] && !rt_sb_r[RT_N].in_zone |-> (rt_m != '0))
    else $error("zero magnitude outside the dead zone");

  a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d1_v_r[D1_N] && !d1_sb_r[D1_N].in_zone |-> (e_s <= FULL_Q))
    else $error("rescaled magnitude above full scale");

endmodule

`default_nettype wire
